[sv/q2e_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_pkg: shared types and constants
// Constants, angle table and payload types for the quaternion to Euler block.
// ---------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;

  localparam int CordicStages = 16;
  localparam int TableLen     = 24;
  localparam int IsqrtSteps   = 29;   // result bits of the square root

  // Working width of the CORDIC vectors: arguments stay below 2^40.
  localparam int VecW = 44;
  localparam int AngW = 33;           // Q3.29 accumulator with headroom

  localparam logic signed [AngW-1:0] PiQ29 = 33'sd1686629713;
  localparam logic signed [AngW-1:0] PitchLim = 33'sd12868;
  localparam logic signed [AngW-1:0] AngleLim = 33'sd25736;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [AngW-1:0] ang_t;

  typedef struct packed {
    logic               sample_valid;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [23:0] pos_x_in;
    logic signed [23:0] pos_y_in;
    logic signed [23:0] pos_z_in;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
    logic signed [23:0] pos_x_out;
    logic signed [23:0] pos_y_out;
    logic signed [23:0] pos_z_out;
  } result_t;

  // Per-sample side data that travels with the CORDIC cells.
  typedef struct packed {
    logic               sat_pos;
    logic               sat_neg;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
  } side_t;

  function automatic ang_t atan_entry(input int i);
    logic [28:0] t;
    case (i)
      0: t = 29'd421657428;
      1: t = 29'd248918915;
      2: t = 29'd131521918;
      3: t = 29'd66762579;
      4: t = 29'd33510843;
      5: t = 29'd16771758;
      6: t = 29'd8387925;
      7: t = 29'd4194219;
      8: t = 29'd2097141;
      9: t = 29'd1048575;
      default: t = 29'd524288 >> (i - 10);
    endcase
    return ang_t'({4'd0, t});
  endfunction

endpackage
`default_nettype wire

[sv/q2e_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_if: valid/ready channel
// Carries one sample or result transaction per handshake.
// ---------------------------------------------------------------------------
`default_nettype none
interface q2e_sample_if;
  logic              valid;
  logic              ready;
  q2e_pkg::sample_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface q2e_result_if;
  logic              valid;
  logic              ready;
  q2e_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/q2e_isqrt_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_isqrt_cell: one step of the restoring square root
// Settles one result bit per cell and hands the remainder on.
// ---------------------------------------------------------------------------
`default_nettype none
module q2e_isqrt_cell (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [4:0]  step,
  input  wire logic [57:0] rem_in,
  input  wire logic [28:0] root_in,
  output      logic [57:0] rem,
  output      logic [28:0] root
);
  // Bit weight of this step is 4^(28-step) against res<<1 form.
  logic [5:0]  sh;
  logic [57:0] trial;
  logic [57:0] bitv;
  always_comb begin
    sh    = 6'd29 - {1'b0, step};
    bitv  = 58'd1 << {sh - 6'd1, 1'b0};
    trial = ({29'd0, root_in} << sh) + bitv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem  <= rem_in - trial;
        root <= root_in | (29'd1 << (sh - 6'd1));
      end else begin
        rem  <= rem_in;
        root <= root_in;
      end
    end
  end
endmodule
`default_nettype wire

[sv/q2e_cordic_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the vector toward the x axis and accumulates the angle.
// ---------------------------------------------------------------------------
`default_nettype none
module q2e_cordic_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [4:0]     step,
  input  wire q2e_pkg::ang_t  atan,
  input  wire q2e_pkg::vec_t  x_in,
  input  wire q2e_pkg::vec_t  y_in,
  input  wire q2e_pkg::ang_t  z_in,
  output      q2e_pkg::vec_t  x,
  output      q2e_pkg::vec_t  y,
  output      q2e_pkg::ang_t  z
);
  q2e_pkg::vec_t dx, dy;
  always_comb begin
    dx = y_in >>> step;
    dy = x_in >>> step;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[q2e_pkg::VecW-1]) begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + atan;
      end else begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - atan;
      end
    end
  end
endmodule
`default_nettype wire

[sv/q2e_atan2.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_atan2: pipelined vectoring CORDIC
// Quadrant fold, a row of CORDIC cells, then round and clamp to Q3.13.
// ---------------------------------------------------------------------------
`default_nettype none
module q2e_atan2 (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire q2e_pkg::vec_t  y_in,
  input  wire q2e_pkg::vec_t  x_in,
  input  wire q2e_pkg::ang_t  lim,
  output      logic signed [15:0] angle
);
  localparam int N = q2e_pkg::CordicStages;
  q2e_pkg::vec_t xs [N+1];
  q2e_pkg::vec_t ys [N+1];
  q2e_pkg::ang_t zs [N+1];
  logic          zero [N+1];
  q2e_pkg::ang_t zr;
  q2e_pkg::ang_t zf;

  // Fold stage: vectors with negative x are turned through pi first.
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[q2e_pkg::VecW-1]) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= y_in[q2e_pkg::VecW-1] ? -q2e_pkg::PiQ29 : q2e_pkg::PiQ29;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    q2e_cordic_cell u_cell (
      .clk(clk), .en(en), .step(5'(i)), .atan(q2e_pkg::atan_entry(i)),
      .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x(xs[i+1]), .y(ys[i+1]), .z(zs[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) zero[i+1] <= zero[i];
    end
  end

  always_comb begin
    zr = (zs[N] + q2e_pkg::ang_t'(32768)) >>> 16;
    if (zero[N])      zf = '0;
    else if (zr > lim) zf = lim;
    else if (zr < -lim) zf = -lim;
    else              zf = zr;
  end

  always_ff @(posedge clk) begin
    if (en) angle <= zf[15:0];
  end
endmodule
`default_nettype wire

[sv/quaternion_to_euler_angles.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles: ZYX Euler angles from a unit quaternion
// Products, a pipelined square root for pitch and three CORDIC rows.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload
// sample    in   sample_valid, quat_w..z (Q2.14), pos_x/y/z_in (mm)
// result    out  pitch (Q2.13), roll/yaw (Q3.13), pos_x/y/z_out (mm)
//
// One transaction per cycle while the result side is not stalled; the stages are
// products, arguments and root load, the square-root cells, the CORDIC fold,
// the CORDIC cell row and the output register.
// Samples with sample_valid low are dropped at the input.
// The whole pipe advances only when the output stage is free or being read,
// so a stall on the result side holds every stage. Reset clears valid bits.
// ---------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_angles (
  input wire logic     clk,
  input wire logic     rst,
  q2e_sample_if.sink   sample,
  q2e_result_if.source result
);
  localparam int Nq = q2e_pkg::IsqrtSteps;
  localparam int Nc = q2e_pkg::CordicStages;

  logic en;
  assign en = !result.valid || result.ready;
  assign sample.ready = en;

  // Stage 1: products.
  logic signed [31:0] p_wy, p_xz, p_wx, p_yz, p_xx, p_yy, p_xy, p_wz, p_zz;
  q2e_pkg::side_t side1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wy <= sample.data.quat_w * sample.data.quat_y;
      p_xz <= sample.data.quat_x * sample.data.quat_z;
      p_wx <= sample.data.quat_w * sample.data.quat_x;
      p_yz <= sample.data.quat_y * sample.data.quat_z;
      p_xx <= sample.data.quat_x * sample.data.quat_x;
      p_yy <= sample.data.quat_y * sample.data.quat_y;
      p_xy <= sample.data.quat_x * sample.data.quat_y;
      p_wz <= sample.data.quat_w * sample.data.quat_z;
      p_zz <= sample.data.quat_z * sample.data.quat_z;
      side1.px <= sample.data.pos_x_in;
      side1.pz <= sample.data.pos_z_in;
      side1.py <= (sample.data.pos_y_in == 24'sh800000) ? 24'sh7fffff
                                                       : -sample.data.pos_y_in;
      side1.sat_pos <= 1'b0;
      side1.sat_neg <= 1'b0;
    end
  end

  // Stage 2: arguments and saturation flags; the square-root operand 2^56 - s^2
  // is formed in stage 3 by squaring s (|s| < 2^28 when used, 29 bits each side).
  q2e_pkg::vec_t s2, ry2, rx2, yy2, yx2;
  logic signed [34:0] s_c;
  q2e_pkg::side_t side2;
  q2e_pkg::side_t side2_next;
  always_comb begin
    s_c = 35'(p_wy) - 35'(p_xz);
    s_c = s_c <<< 1;
    side2_next = side1;
    side2_next.sat_pos = s_c >= 35'sd268435456;
    side2_next.sat_neg = s_c <= -35'sd268435456;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= q2e_pkg::VecW'(s_c);
      ry2 <= q2e_pkg::VecW'((36'(p_wx) + 36'(p_yz)) <<< 1);
      rx2 <= (q2e_pkg::vec_t'(1) <<< 28) - q2e_pkg::VecW'((36'(p_xx) + 36'(p_yy)) <<< 1);
      yy2 <= q2e_pkg::VecW'((36'(p_xy) + 36'(p_wz)) <<< 1);
      yx2 <= (q2e_pkg::vec_t'(1) <<< 28) - q2e_pkg::VecW'((36'(p_yy) + 36'(p_zz)) <<< 1);
      side2 <= side2_next;
    end
  end

  // Stage 3: square of the argument magnitude.
  logic [28:0] s_mag;
  logic [57:0] s_sq;
  assign s_mag = s2[q2e_pkg::VecW-1] ? 29'(-s2) : 29'(s2);
  assign s_sq  = 58'(s_mag) * 58'(s_mag);

  // Square-root cells, with all other values delayed alongside.
  logic [57:0] rem [Nq+1];
  logic [28:0] root [Nq+1];
  q2e_pkg::vec_t d_s [Nq+1];
  q2e_pkg::vec_t d_ry [Nq+1];
  q2e_pkg::vec_t d_rx [Nq+1];
  q2e_pkg::vec_t d_yy [Nq+1];
  q2e_pkg::vec_t d_yx [Nq+1];
  q2e_pkg::side_t d_sd [Nq+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= (side2.sat_pos || side2.sat_neg) ? '0 : (58'd1 << 56) - s_sq;
      root[0] <= '0;
      d_s[0]  <= s2;  d_ry[0] <= ry2; d_rx[0] <= rx2;
      d_yy[0] <= yy2; d_yx[0] <= yx2; d_sd[0] <= side2;
    end
  end

  for (genvar k = 0; k < Nq; k++) begin : g_sq
    q2e_isqrt_cell u_sq (
      .clk(clk), .en(en), .step(5'(k)), .rem_in(rem[k]), .root_in(root[k]),
      .rem(rem[k+1]), .root(root[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        d_s[k+1] <= d_s[k];   d_ry[k+1] <= d_ry[k]; d_rx[k+1] <= d_rx[k];
        d_yy[k+1] <= d_yy[k]; d_yx[k+1] <= d_yx[k]; d_sd[k+1] <= d_sd[k];
      end
    end
  end

  logic signed [15:0] pitch_c, roll_c, yaw_c;
  q2e_atan2 u_pitch (.clk(clk), .en(en), .y_in(d_s[Nq]),
    .x_in(q2e_pkg::vec_t'({15'd0, root[Nq]})), .lim(q2e_pkg::PitchLim), .angle(pitch_c));
  q2e_atan2 u_roll (.clk(clk), .en(en), .y_in(d_ry[Nq]), .x_in(d_rx[Nq]),
    .lim(q2e_pkg::AngleLim), .angle(roll_c));
  q2e_atan2 u_yaw (.clk(clk), .en(en), .y_in(d_yy[Nq]), .x_in(d_yx[Nq]),
    .lim(q2e_pkg::AngleLim), .angle(yaw_c));

  q2e_pkg::side_t d_out [Nc+2];
  always_ff @(posedge clk) begin
    if (en) d_out[0] <= d_sd[Nq];
  end
  for (genvar j = 0; j < Nc + 1; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) d_out[j+1] <= d_out[j];
    end
  end

  // d_out[Nc+1] lines up with the registered angles.
  always_comb begin
    result.data.roll_angle = roll_c;
    result.data.yaw_angle  = yaw_c;
    if (d_out[Nc+1].sat_pos)      result.data.pitch_angle = 15'sd12868;
    else if (d_out[Nc+1].sat_neg) result.data.pitch_angle = -15'sd12868;
    else                          result.data.pitch_angle = pitch_c[14:0];
    result.data.pos_x_out = d_out[Nc+1].px;
    result.data.pos_y_out = d_out[Nc+1].py;
    result.data.pos_z_out = d_out[Nc+1].pz;
  end

  // Valid bits: products, arguments and root load 3, root cells Nq, fold 1,
  // CORDIC cells Nc, output register 1.
  localparam int Lat = 3 + Nq + 1 + Nc + 1;
  logic [Lat-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[Lat-2:0], sample.valid && sample.data.sample_valid};
    end
  end
  assign result.valid = vpipe[Lat-1];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.data))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    sample.ready == (!result.valid || result.ready))
    else $error("input ready does not follow output stage");
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.pitch_angle <= 15'sd12868 &&
                     result.data.pitch_angle >= -15'sd12868)
    else $error("pitch beyond limit");
endmodule
`default_nettype wire
